FILE: design/frequency_ranked_band_list_macros.svh
// assertion macros for the frequency ranked band list
`ifndef FREQUENCY_RANKED_BAND_LIST_MACROS_SVH
`define FREQUENCY_RANKED_BAND_LIST_MACROS_SVH

// property checked on every rising edge outside reset
`define FRBL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition in one cycle implies a consequence in the next
`define FRBL_ASSERT_NEXT(label, ante, cons, msg) \
	`FRBL_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: design/frbl_pkg.sv
// package with sizes, codes, types and helpers of the frequency ranked band list
`default_nettype none

package frbl_pkg;

	localparam int NUM_CHANNELS = 64;
	localparam int COUNT_WIDTH  = 16;
	localparam int STORE_DEPTH  = 64;
	localparam int LIST_CAP     = (NUM_CHANNELS < STORE_DEPTH) ? NUM_CHANNELS : STORE_DEPTH;

	// fixed field widths
	localparam int MODE_W = 2;
	localparam int CHAN_W = 6;
	localparam int SLOT_W = 6;
	localparam int POS_W  = 6;
	localparam int ECNT_W = 16;
	localparam int LLEN_W = 7;

	// store addressing and list length
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int LEN_W = $clog2(STORE_DEPTH + 1);

	localparam logic [LEN_W-1:0]       LIST_CAP_LEN = LEN_W'(LIST_CAP);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_BUMP   = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_READ   = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_ABSENT,
		ST_MOVE_RD,
		ST_MOVE_EV,
		ST_PLACE,
		ST_SHIFT_RD,
		ST_SHIFT_EV,
		ST_READ_RD,
		ST_READ_EV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CHAN_W-1:0]      channel;
		logic [COUNT_WIDTH-1:0] count;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} wr_req_t;

	typedef struct packed {
		logic                   found;
		logic [IDX_W-1:0]       position;
		logic [CHAN_W-1:0]      channel;
		logic [COUNT_WIDTH-1:0] count;
		logic [LEN_W-1:0]       length;
	} result_t;

	// count raised by one, held at the maximum
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		logic [COUNT_WIDTH-1:0] r;
		r = (c == COUNT_MAX) ? c : c + COUNT_WIDTH'(1);
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/frbl_req_if.sv
// request channel carrying one list command item
`default_nettype none

interface frbl_req_if;
	logic                        valid;
	logic                        ready;
	logic [frbl_pkg::MODE_W-1:0] mode;
	logic [frbl_pkg::CHAN_W-1:0] channel;
	logic [frbl_pkg::SLOT_W-1:0] slot;

	modport source (output valid, mode, channel, slot, input ready);
	modport sink   (input valid, mode, channel, slot, output ready);
endinterface

`default_nettype wire

FILE: design/frbl_rsp_if.sv
// response channel carrying one list result item
`default_nettype none

interface frbl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [frbl_pkg::POS_W-1:0]  position;
	logic [frbl_pkg::CHAN_W-1:0] entry_channel;
	logic [frbl_pkg::ECNT_W-1:0] entry_count;
	logic [frbl_pkg::LLEN_W-1:0] list_length;

	modport source (output valid, found, position, entry_channel, entry_count, list_length,
		input ready);
	modport sink   (input valid, found, position, entry_channel, entry_count, list_length,
		output ready);
endinterface

`default_nettype wire

FILE: design/frbl_store.sv
// entry store: one write port, one read port with registered read data
`default_nettype none

module frbl_store (
	input  wire logic                        clk,
	input  wire frbl_pkg::wr_req_t           wr,
	input  wire logic [frbl_pkg::IDX_W-1:0]  rd_addr,
	output frbl_pkg::entry_t                 rd_data
);

	frbl_pkg::entry_t mem [frbl_pkg::STORE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read port, read data registered
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: design/frequency_ranked_band_list.sv
// Steps: a no-op or a read past the length goes straight to emit; a read reads one entry;
// an absent channel is a read and compare per entry, then an append if bumping and not full;
// a found bump then moves each entry it passes down by a read and a write-back, and a found
// remove shifts each later entry up the same way. One item at a time: the next is taken once
// the result is loaded into the output register, as every step is a read then a write-back
// through the store. Reset clears the list length and all control; the entry store is not
// cleared, as entries at or beyond the length are never read.
`default_nettype none

`include "frequency_ranked_band_list_macros.svh"

module frequency_ranked_band_list (
	input wire logic  clk,
	input wire logic  arst_n,
	frbl_req_if.sink  req,
	frbl_rsp_if.source rsp
);

	localparam int IDX_W = frbl_pkg::IDX_W;
	localparam int LEN_W = frbl_pkg::LEN_W;
	localparam int CW    = frbl_pkg::COUNT_WIDTH;

	frbl_pkg::state_t state_q, state_d;
	logic [LEN_W-1:0] len_q, len_d;

	// item being worked on
	logic [frbl_pkg::MODE_W-1:0] mode_q;
	logic [frbl_pkg::CHAN_W-1:0] ch_q;
	logic [IDX_W-1:0]            slot_q;
	logic [IDX_W-1:0]            idx_q, idx_d;
	logic [IDX_W-1:0]            pos_q, pos_d;
	logic [CW-1:0]               cnt_q, cnt_d;
	logic                        fnd_q, fnd_d;
	logic [frbl_pkg::CHAN_W-1:0] ech_q, ech_d;

	// output register
	logic               out_vld_q;
	frbl_pkg::result_t  out_q;
	logic               out_load;
	logic               accept;

	// store access
	frbl_pkg::wr_req_t wr;
	logic [IDX_W-1:0]  rd_addr;
	frbl_pkg::entry_t  rd_data;

	frbl_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept = req.valid && req.ready;

	// sequencer: search, then bubble up, shift down, append or read
	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		cnt_d    = cnt_q;
		fnd_d    = fnd_q;
		ech_d    = ech_q;
		rd_addr  = '0;
		wr       = '0;
		out_load = 1'b0;
		req.ready = 1'b0;

		unique case (state_q)
			frbl_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					idx_d = '0;
					pos_d = '0;
					cnt_d = '0;
					fnd_d = 1'b0;
					ech_d = '0;
					unique case (req.mode)
						frbl_pkg::MODE_BUMP, frbl_pkg::MODE_REMOVE: begin
							state_d = (len_q == '0) ? frbl_pkg::ST_ABSENT
								: frbl_pkg::ST_SCAN_RD;
						end
						frbl_pkg::MODE_READ: begin
							pos_d = IDX_W'(req.slot);
							state_d = (LEN_W'(req.slot) < len_q) ? frbl_pkg::ST_READ_RD
								: frbl_pkg::ST_EMIT;
						end
						default: begin
							state_d = frbl_pkg::ST_EMIT;
						end
					endcase
				end
			end
			frbl_pkg::ST_SCAN_RD: begin
				rd_addr = idx_q;
				state_d = frbl_pkg::ST_SCAN_EV;
			end
			frbl_pkg::ST_SCAN_EV: begin
				if (rd_data.channel == ch_q) begin
					fnd_d = 1'b1;
					ech_d = ch_q;
					pos_d = idx_q;
					if (mode_q == frbl_pkg::MODE_BUMP) begin
						cnt_d = frbl_pkg::sat_inc(rd_data.count);
						state_d = (idx_q == '0) ? frbl_pkg::ST_PLACE : frbl_pkg::ST_MOVE_RD;
					end else begin
						cnt_d = rd_data.count;
						if ((LEN_W'(idx_q) + LEN_W'(1)) < len_q) begin
							state_d = frbl_pkg::ST_SHIFT_RD;
						end else begin
							len_d = len_q - LEN_W'(1);
							state_d = frbl_pkg::ST_EMIT;
						end
					end
				end else if ((LEN_W'(idx_q) + LEN_W'(1)) < len_q) begin
					idx_d = idx_q + IDX_W'(1);
					state_d = frbl_pkg::ST_SCAN_RD;
				end else begin
					state_d = frbl_pkg::ST_ABSENT;
				end
			end
			frbl_pkg::ST_ABSENT: begin
				// append a new channel when bumping, unless the list is full
				if (mode_q == frbl_pkg::MODE_BUMP && len_q < frbl_pkg::LIST_CAP_LEN) begin
					wr.en = 1'b1;
					wr.addr = IDX_W'(len_q);
					wr.data.channel = ch_q;
					wr.data.count = CW'(1);
					len_d = len_q + LEN_W'(1);
					pos_d = IDX_W'(len_q);
					ech_d = ch_q;
					cnt_d = CW'(1);
				end
				state_d = frbl_pkg::ST_EMIT;
			end
			frbl_pkg::ST_MOVE_RD: begin
				rd_addr = idx_q - IDX_W'(1);
				state_d = frbl_pkg::ST_MOVE_EV;
			end
			frbl_pkg::ST_MOVE_EV: begin
				// entry above with a lower count drops one place
				if (rd_data.count < cnt_q) begin
					wr.en = 1'b1;
					wr.addr = idx_q;
					wr.data = rd_data;
					idx_d = idx_q - IDX_W'(1);
					state_d = (idx_q == IDX_W'(1)) ? frbl_pkg::ST_PLACE : frbl_pkg::ST_MOVE_RD;
				end else begin
					state_d = frbl_pkg::ST_PLACE;
				end
			end
			frbl_pkg::ST_PLACE: begin
				wr.en = 1'b1;
				wr.addr = idx_q;
				wr.data.channel = ch_q;
				wr.data.count = cnt_q;
				pos_d = idx_q;
				state_d = frbl_pkg::ST_EMIT;
			end
			frbl_pkg::ST_SHIFT_RD: begin
				rd_addr = idx_q + IDX_W'(1);
				state_d = frbl_pkg::ST_SHIFT_EV;
			end
			frbl_pkg::ST_SHIFT_EV: begin
				// close the gap left by the removed entry
				wr.en = 1'b1;
				wr.addr = idx_q;
				wr.data = rd_data;
				idx_d = idx_q + IDX_W'(1);
				if ((LEN_W'(idx_q) + LEN_W'(2)) < len_q) begin
					state_d = frbl_pkg::ST_SHIFT_RD;
				end else begin
					len_d = len_q - LEN_W'(1);
					state_d = frbl_pkg::ST_EMIT;
				end
			end
			frbl_pkg::ST_READ_RD: begin
				rd_addr = slot_q;
				state_d = frbl_pkg::ST_READ_EV;
			end
			frbl_pkg::ST_READ_EV: begin
				fnd_d = 1'b1;
				ech_d = rd_data.channel;
				cnt_d = rd_data.count;
				state_d = frbl_pkg::ST_EMIT;
			end
			frbl_pkg::ST_EMIT: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d = frbl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frbl_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frbl_pkg::ST_IDLE;
			len_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q <= len_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// working registers of the item
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			ch_q <= req.channel;
			slot_q <= IDX_W'(req.slot);
		end
		idx_q <= idx_d;
		pos_q <= pos_d;
		cnt_q <= cnt_d;
		fnd_q <= fnd_d;
		ech_q <= ech_d;
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.found <= fnd_q;
			out_q.position <= pos_q;
			out_q.channel <= ech_q;
			out_q.count <= cnt_q;
			out_q.length <= len_q;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.found         = out_q.found;
	assign rsp.position      = frbl_pkg::POS_W'(out_q.position);
	assign rsp.entry_channel = out_q.channel;
	assign rsp.entry_count   = frbl_pkg::ECNT_W'(out_q.count);
	assign rsp.list_length   = frbl_pkg::LLEN_W'(out_q.length);

	// states in which the store may be written, and the bubble stop condition
	logic wr_step;
	logic move_stop;
	logic emit_st;

	assign wr_step = (state_q == frbl_pkg::ST_ABSENT) || (state_q == frbl_pkg::ST_MOVE_EV) ||
		(state_q == frbl_pkg::ST_PLACE) || (state_q == frbl_pkg::ST_SHIFT_EV);
	assign move_stop = (state_q == frbl_pkg::ST_MOVE_EV) && (rd_data.count >= cnt_q);
	assign emit_st = (state_q == frbl_pkg::ST_EMIT);

	// checks
	`FRBL_ASSERT(a_len_cap, len_q <= frbl_pkg::LIST_CAP_LEN, "list length beyond capacity")
	`FRBL_ASSERT(a_wr_state, wr.en |-> wr_step, "store written outside a write step")
	`FRBL_ASSERT(a_rsp_from_emit, $rose(out_vld_q) |-> $past(emit_st), "result raised outside emit")
	`FRBL_ASSERT_NEXT(a_move_stop, move_stop, state_q == frbl_pkg::ST_PLACE, "bubble passed a count")

endmodule

`default_nettype wire
